FILE: rtl/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg: shared constants, types and helpers
// binary32 field layout, special encodings and a leading-zero counter.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;
    localparam logic [31:0] FP_HALF    = 32'h3F00_0000;
    localparam logic [15:0] FULL_SCALE = 16'hFFFF;

    typedef struct packed {
        logic        sign;
        logic [7:0]  expo;
        logic [22:0] frac;
    } t_fp;

    // leading zeros of a 27-bit word, 27 when all zero
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/fts_fp_add.sv
// ----------------------------------------------------------------------------
// fts_fp_add: four-stage binary32 adder
// Round to nearest even, subnormals kept, one item per enabled cycle.
// ----------------------------------------------------------------------------
module fts_fp_add (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  logic        i_valid,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_valid,
    output logic [31:0] o_sum
);

    logic [3:0] r_vld;

    // stage 1: unpack, specials, order by magnitude
    fts_pkg::t_fp fa, fb;
    logic         a_nan, b_nan, a_inf, b_inf, swap;
    logic [7:0]   ea, eb, d;
    logic [23:0]  ma, mb;
    logic         n1_spec;
    logic [31:0]  n1_spec_val;

    always_comb begin
        fa    = i_a;
        fb    = i_b;
        a_nan = (&fa.expo) && (|fa.frac);
        b_nan = (&fb.expo) && (|fb.frac);
        a_inf = (&fa.expo) && !(|fa.frac);
        b_inf = (&fb.expo) && !(|fb.frac);
        ea    = (fa.expo == 8'd0) ? 8'd1 : fa.expo;
        eb    = (fb.expo == 8'd0) ? 8'd1 : fb.expo;
        ma    = {|fa.expo, fa.frac};
        mb    = {|fb.expo, fb.frac};
        swap  = {eb, mb} > {ea, ma};
        d     = swap ? (eb - ea) : (ea - eb);
        n1_spec     = 1'b1;
        n1_spec_val = fts_pkg::FP_QNAN;
        if (a_nan || b_nan || (a_inf && b_inf && (fa.sign != fb.sign))) begin
            n1_spec_val = fts_pkg::FP_QNAN;
        end else if (a_inf) begin
            n1_spec_val = i_a;
        end else if (b_inf) begin
            n1_spec_val = i_b;
        end else begin
            n1_spec = 1'b0;
        end
    end

    logic        r1_spec, r1_sign, r1_sub;
    logic [31:0] r1_spec_val;
    logic [7:0]  r1_exp;
    logic [23:0] r1_mbig, r1_msmall;
    logic [4:0]  r1_shift;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_spec     <= n1_spec;
            r1_spec_val <= n1_spec_val;
            r1_sign     <= swap ? fb.sign : fa.sign;
            r1_sub      <= fa.sign ^ fb.sign;
            r1_exp      <= swap ? eb : ea;
            r1_mbig     <= swap ? mb : ma;
            r1_msmall   <= swap ? ma : mb;
            r1_shift    <= (d > 8'd27) ? 5'd27 : d[4:0];
        end
    end

    // stage 2: align with sticky, add or subtract
    logic [26:0] small27, shifted, lost_mask, aligned;
    logic [27:0] big28, n2_sum;

    always_comb begin
        small27   = {r1_msmall, 3'b000};
        shifted   = small27 >> r1_shift;
        lost_mask = (27'd1 << r1_shift) - 27'd1;
        aligned   = {shifted[26:1], shifted[0] | (|(small27 & lost_mask))};
        big28     = {1'b0, r1_mbig, 3'b000};
        n2_sum    = r1_sub ? (big28 - {1'b0, aligned}) : (big28 + {1'b0, aligned});
    end

    logic        r2_spec, r2_sign, r2_sub;
    logic [31:0] r2_spec_val;
    logic [7:0]  r2_exp;
    logic [27:0] r2_sum;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_spec     <= r1_spec;
            r2_spec_val <= r1_spec_val;
            r2_sign     <= r1_sign;
            r2_sub      <= r1_sub;
            r2_exp      <= r1_exp;
            r2_sum      <= n2_sum;
        end
    end

    // stage 3: normalize, left shift held at the subnormal boundary
    logic [4:0]  lz, sh;
    logic [7:0]  lim;
    logic [26:0] n3_n;
    logic [8:0]  n3_e;

    always_comb begin
        lz  = fts_pkg::lzc27(r2_sum[26:0]);
        lim = r2_exp - 8'd1;
        sh  = ({3'b000, lz} > lim) ? lim[4:0] : lz;
        if (r2_sum[27]) begin
            n3_n = {r2_sum[27:2], r2_sum[1] | r2_sum[0]};
            n3_e = {1'b0, r2_exp} + 9'd1;
        end else begin
            n3_n = r2_sum[26:0] << sh;
            n3_e = {1'b0, r2_exp} - {4'b0000, sh};
        end
    end

    logic        r3_spec, r3_sign, r3_sub, r3_zero;
    logic [31:0] r3_spec_val;
    logic [26:0] r3_n;
    logic [8:0]  r3_e;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r3_spec     <= r2_spec;
            r3_spec_val <= r2_spec_val;
            r3_sign     <= r2_sign;
            r3_sub      <= r2_sub;
            r3_zero     <= (r2_sum == 28'd0);
            r3_n        <= n3_n;
            r3_e        <= n3_e;
        end
    end

    // stage 4: round to nearest even and pack; carry may reach infinity
    logic        up;
    logic [7:0]  efield;
    logic [30:0] packed_mag;
    logic [31:0] n4_sum;

    always_comb begin
        up         = r3_n[2] & ((|r3_n[1:0]) | r3_n[3]);
        efield     = r3_n[26] ? r3_e[7:0] : 8'd0;
        packed_mag = {efield, r3_n[25:3]} + 31'(up);
        if (r3_spec) begin
            n4_sum = r3_spec_val;
        end else if (r3_zero) begin
            // exact cancellation gives +0, two like-signed zeros keep the sign
            n4_sum = {r3_sub ? 1'b0 : r3_sign, 31'd0};
        end else if (r3_e >= 9'd255) begin
            n4_sum = {r3_sign, 8'hFF, 23'd0};
        end else begin
            n4_sum = {r3_sign, packed_mag};
        end
    end

    logic [31:0] r4_sum;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r4_sum <= n4_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign o_valid = r_vld[3];
    assign o_sum   = r4_sum;

endmodule

FILE: rtl/fts_fp_div.sv
// ----------------------------------------------------------------------------
// fts_fp_div: pipelined binary32 divider
// Restoring division, one quotient bit per stage, round to nearest even.
// ----------------------------------------------------------------------------
module fts_fp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  logic        i_valid,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_valid,
    output logic [31:0] o_quot
);

    localparam int STEPS = 25;  // 24 mantissa bits plus guard

    typedef struct packed {
        logic [24:0]        rem;
        logic [24:0]        q;
        logic [23:0]        mb;
        logic signed [10:0] eq;
        logic               sign;
        logic               spec;
        logic [31:0]        spec_val;
    } t_dstage;

    logic [STEPS+2:0] r_vld;

    // stage 1: unpack, specials, normalize subnormal mantissas
    fts_pkg::t_fp      fa, fb;
    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic [7:0]        ea, eb;
    logic [23:0]       ma, mb;
    logic [4:0]        lza, lzb;
    logic              n1_spec;
    logic [31:0]       n1_spec_val;

    always_comb begin
        fa     = i_a;
        fb     = i_b;
        sgn    = fa.sign ^ fb.sign;
        a_nan  = (&fa.expo) && (|fa.frac);
        b_nan  = (&fb.expo) && (|fb.frac);
        a_inf  = (&fa.expo) && !(|fa.frac);
        b_inf  = (&fb.expo) && !(|fb.frac);
        a_zero = (fa.expo == 8'd0) && !(|fa.frac);
        b_zero = (fb.expo == 8'd0) && !(|fb.frac);
        ea     = (fa.expo == 8'd0) ? 8'd1 : fa.expo;
        eb     = (fb.expo == 8'd0) ? 8'd1 : fb.expo;
        ma     = {|fa.expo, fa.frac};
        mb     = {|fb.expo, fb.frac};
        lza    = fts_pkg::lzc27({ma, 3'b111});
        lzb    = fts_pkg::lzc27({mb, 3'b111});
        n1_spec     = 1'b1;
        n1_spec_val = fts_pkg::FP_QNAN;
        if (a_nan || b_nan || (a_zero && b_zero) || (a_inf && b_inf)) begin
            n1_spec_val = fts_pkg::FP_QNAN;
        end else if (a_inf || b_zero) begin
            n1_spec_val = {sgn, 8'hFF, 23'd0};
        end else if (a_zero || b_inf) begin
            n1_spec_val = {sgn, 31'd0};
        end else begin
            n1_spec = 1'b0;
        end
    end

    logic               r1_spec, r1_sign;
    logic [31:0]        r1_spec_val;
    logic [23:0]        r1_ma, r1_mb;
    logic signed [9:0]  r1_ea, r1_eb;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_spec     <= n1_spec;
            r1_spec_val <= n1_spec_val;
            r1_sign     <= sgn;
            r1_ma       <= ma << lza;
            r1_mb       <= mb << lzb;
            r1_ea       <= $signed({2'b00, ea}) - $signed({5'd0, lza});
            r1_eb       <= $signed({2'b00, eb}) - $signed({5'd0, lzb});
        end
    end

    // stage 2: line up dividend so the quotient lands in [1, 2)
    logic    lt;
    t_dstage n2_st;

    always_comb begin
        lt             = r1_ma < r1_mb;
        n2_st.rem      = lt ? {r1_ma, 1'b0} : {1'b0, r1_ma};
        n2_st.q        = '0;
        n2_st.mb       = r1_mb;
        n2_st.eq       = $signed({r1_ea[9], r1_ea}) - $signed({r1_eb[9], r1_eb})
                         + 11'sd127 - $signed({10'd0, lt});
        n2_st.sign     = r1_sign;
        n2_st.spec     = r1_spec;
        n2_st.spec_val = r1_spec_val;
    end

    t_dstage r_st [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_st[0] <= n2_st;
        end
    end

    // one compare-subtract per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic        ge;
        logic [24:0] diff;
        t_dstage     n_st;

        always_comb begin
            ge         = r_st[k].rem >= {1'b0, r_st[k].mb};
            diff       = ge ? (r_st[k].rem - {1'b0, r_st[k].mb}) : r_st[k].rem;
            n_st       = r_st[k];
            n_st.rem   = {diff[23:0], 1'b0};
            n_st.q     = {r_st[k].q[23:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    // final stage: round and pack; quotients below the normal range flush
    // to a signed zero
    t_dstage     fin;
    logic        up;
    logic [30:0] packed_mag;
    logic [31:0] n_quot;

    always_comb begin
        fin        = r_st[STEPS];
        up         = fin.q[0] & ((|fin.rem) | fin.q[1]);
        packed_mag = {fin.eq[7:0], fin.q[23:1]} + 31'(up);
        if (fin.spec) begin
            n_quot = fin.spec_val;
        end else if (fin.eq >= 11'sd255) begin
            n_quot = {fin.sign, 8'hFF, 23'd0};
        end else if (fin.eq <= 11'sd0) begin
            n_quot = {fin.sign, 31'd0};
        end else begin
            n_quot = {fin.sign, packed_mag};
        end
    end

    logic [31:0] r_quot;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_quot <= n_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[STEPS+1:0], i_valid};
        end
    end

    assign o_valid = r_vld[STEPS+2];
    assign o_quot  = r_quot;

endmodule

FILE: rtl/float_to_u16_scaled_convert_top.sv
// ----------------------------------------------------------------------------
// float_to_u16_scaled_convert_top: binary32 to saturated u16 converter
// Computes trunc(((value - offset) / scale) + 0.5) clamped to 0..65535.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries three binary32 patterns per item; output stream
//   carries one 16-bit result per item, in input order.
//   Pipeline: subtract (4 stages), divide (28 stages: unpack, line-up,
//   25 quotient-bit stages, round), add 0.5 (4 stages), truncate/clamp
//   (1 stage), output register (1 stage).
//   Throughput: one item per cycle, set by the one-bit-per-stage divider,
//   as long as a full skid register does not freeze the pipeline.
//   NaN gives 0, +inf or >= 65536 gives 65535, anything below 1 gives 0.
//   Reset (synchronous, active low) empties every stage; nothing is held.
//   Receiver stall: the output register holds its item and a skid register
//   catches the next one; only when the skid is full does the whole
//   pipeline freeze and o_s_axis_tready fall. No item is lost or repeated.
// ----------------------------------------------------------------------------
module float_to_u16_scaled_convert_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] value_bits, [63:32] scale_bits, [95:64] offset_bits
    input  logic [95:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] fixed_result
    output logic [15:0] o_m_axis_tdata
);

    localparam int SUB_STAGES = 4;

    logic ce;  // global pipeline advance

    // ---- value - offset (offset sign flipped into an add) ----
    logic [31:0] value_bits, scale_bits, offset_bits;
    logic        diff_vld;
    logic [31:0] diff_bits;

    assign value_bits  = i_s_axis_tdata[31:0];
    assign scale_bits  = i_s_axis_tdata[63:32];
    assign offset_bits = i_s_axis_tdata[95:64];

    fts_fp_add u_sub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_s_axis_tvalid),
        .i_a     (value_bits),
        .i_b     ({~offset_bits[31], offset_bits[30:0]}),
        .o_valid (diff_vld),
        .o_sum   (diff_bits)
    );

    // scale travels beside the subtractor
    logic [31:0] r_scale_dly [0:SUB_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_scale_dly[0] <= scale_bits;
            for (int k = 1; k < SUB_STAGES; k++) begin
                r_scale_dly[k] <= r_scale_dly[k-1];
            end
        end
    end

    // ---- divide by scale ----
    logic        quot_vld;
    logic [31:0] quot_bits;

    fts_fp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (diff_vld),
        .i_a     (diff_bits),
        .i_b     (r_scale_dly[SUB_STAGES-1]),
        .o_valid (quot_vld),
        .o_quot  (quot_bits)
    );

    // ---- add 0.5 ----
    logic        sum_vld;
    logic [31:0] sum_bits;

    fts_fp_add u_add_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (quot_vld),
        .i_a     (quot_bits),
        .i_b     (fts_pkg::FP_HALF),
        .o_valid (sum_vld),
        .o_sum   (sum_bits)
    );

    // ---- truncate toward zero and clamp ----
    fts_pkg::t_fp fs;
    logic [7:0]   rshift;
    logic [23:0]  int_part;
    logic [15:0]  n_res;

    always_comb begin
        fs       = sum_bits;
        rshift   = 8'd150 - fs.expo;      // 8..23 in the in-range case
        int_part = {1'b1, fs.frac} >> rshift[4:0];
        if ((&fs.expo) && (|fs.frac)) begin
            n_res = 16'd0;                 // NaN
        end else if (fs.sign) begin
            n_res = 16'd0;                 // negative, -0 or -inf
        end else if (fs.expo >= 8'd143) begin
            n_res = fts_pkg::FULL_SCALE;   // >= 65536 or +inf
        end else if (fs.expo < 8'd127) begin
            n_res = 16'd0;                 // below one
        end else begin
            n_res = int_part[15:0];
        end
    end

    logic        r_res_vld;
    logic [15:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (ce) begin
            r_res_vld <= sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_res <= n_res;
        end
    end

    // ---- output register plus skid ----
    logic        r_out_vld, r_skid_vld;
    logic [15:0] r_out, r_skid;
    logic        push;

    assign ce   = !r_skid_vld;
    assign push = ce && r_res_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && i_m_axis_tready) begin
            if (r_skid_vld) begin
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= push;
            end
        end else if (!r_out_vld) begin
            r_out_vld <= push;
        end else if (push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && i_m_axis_tready) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= r_res;
            end
        end else if (!r_out_vld) begin
            if (push) begin
                r_out <= r_res;
            end
        end else if (push) begin
            r_skid <= r_res;
        end
    end

    assign o_s_axis_tready = ce;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

endmodule

FILE: test/conv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv_checker: predictor and scoreboard for the float to u16 converter
// Rebuilds each result with bit-exact binary32 subtract, divide and add
// (round to nearest even, subnormals included), then truncates and clamps.
// ----------------------------------------------------------------------------
module conv_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [95:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [7:0] EXP_MAX   = 8'hFF;
    localparam logic [7:0] EXP_BIAS  = 8'd127;
    localparam int         GUARD     = 39;
    localparam int         MIN_QEXP  = -149;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    logic [15:0] expected_q[$];
    int          fails;
    int          n_out;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic bit fp_is_nan(input logic [31:0] b);
        return b[30:23] == EXP_MAX && b[22:0] != 0;
    endfunction

    function automatic bit fp_is_inf(input logic [31:0] b);
        return b[30:23] == EXP_MAX && b[22:0] == 0;
    endfunction

    function automatic bit fp_is_zero(input logic [31:0] b);
        return b[30:0] == 0;
    endfunction

    // value = m * 2^e
    function automatic void fp_unpack(input logic [31:0] b, output logic [63:0] m,
                                      output int e);
        if (b[30:23] == 0) begin
            m = 64'(b[22:0]);
            e = MIN_QEXP;
        end else begin
            m = 64'({1'b1, b[22:0]});
            e = int'(b[30:23]) - 150;
        end
    endfunction

    // round m * 2^e (plus sticky below) to binary32, nearest even
    function automatic logic [31:0] fp_round_pack(input logic s, input logic [63:0] m,
                                                  input int e, input bit st);
        int          p;
        int          qexp;
        int          sh;
        logic [63:0] kept;
        bit          rb;
        bit          stk;
        if (m == 0)
            return {s, 31'd0};
        p = 63;
        while (!m[p])
            p--;
        qexp = (p + e - 23 > MIN_QEXP) ? p + e - 23 : MIN_QEXP;
        sh   = qexp - e;
        rb   = 1'b0;
        stk  = st;
        if (sh <= 0) begin
            kept = m << (-sh);
        end else if (sh > 64) begin
            kept = 0;
            stk  = 1'b1;
        end else begin
            kept = (sh == 64) ? 64'd0 : m >> sh;
            rb   = m[sh-1];
            if (sh > 1 && (m & ((64'd1 << (sh - 1)) - 1)) != 0)
                stk = 1'b1;
        end
        if (rb && (stk || kept[0]))
            kept++;
        if (kept == (64'd1 << 24)) begin
            kept = 64'd1 << 23;
            qexp++;
        end
        if (kept < (64'd1 << 23))
            return {s, 8'd0, kept[22:0]};
        if (qexp + 150 >= 255)
            return {s, EXP_MAX, 23'd0};
        return {s, 8'(qexp + 150), kept[22:0]};
    endfunction

    function automatic logic [63:0] align_mant(input logic [63:0] m, input int e,
                                               input int base);
        int d;
        d = base - e;
        if (d <= GUARD)
            return m << (GUARD - d);
        if (d - GUARD >= 64)
            return 64'(m != 0);
        return (m >> (d - GUARD)) | 64'((m & ((64'd1 << (d - GUARD)) - 1)) != 0);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] ma, mb, xa, xb;
        int          ea, eb, base;
        if (fp_is_nan(a) || fp_is_nan(b))
            return fts_pkg::FP_QNAN;
        if (fp_is_inf(a))
            return (fp_is_inf(b) && a[31] != b[31]) ? fts_pkg::FP_QNAN : a;
        if (fp_is_inf(b))
            return b;
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        if (ma == 0 && mb == 0)
            return {a[31] & b[31], 31'd0};
        base = (ea > eb) ? ea : eb;
        xa   = align_mant(ma, ea, base);
        xb   = align_mant(mb, eb, base);
        if (a[31] == b[31])
            return fp_round_pack(a[31], xa + xb, base - GUARD, 1'b0);
        // exact cancellation gives +0
        if (xa == xb)
            return 32'd0;
        if (xa > xb)
            return fp_round_pack(a[31], xa - xb, base - GUARD, 1'b0);
        return fp_round_pack(b[31], xb - xa, base - GUARD, 1'b0);
    endfunction

    function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] ma, mb, q, r;
        int          ea, eb;
        logic        s;
        s = a[31] ^ b[31];
        if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && fp_is_inf(b))
            || (fp_is_zero(a) && fp_is_zero(b)))
            return fts_pkg::FP_QNAN;
        if (fp_is_inf(a) || fp_is_zero(b))
            return {s, EXP_MAX, 23'd0};
        if (fp_is_inf(b) || fp_is_zero(a))
            return {s, 31'd0};
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        while (!ma[23]) begin
            ma = ma << 1;
            ea--;
        end
        while (!mb[23]) begin
            mb = mb << 1;
            eb--;
        end
        q = (ma << GUARD) / mb;
        r = (ma << GUARD) % mb;
        return fp_round_pack(s, q, ea - eb - GUARD, r != 0);
    endfunction

    function automatic logic [15:0] trunc_clamp_u16(input logic [31:0] t);
        if (fp_is_nan(t) || t[31] || t[30:23] < EXP_BIAS)
            return 16'd0;
        if (t[30:23] >= EXP_BIAS + 8'd16)
            return fts_pkg::FULL_SCALE;
        return 16'(({1'b1, t[22:0]}) >> (150 - int'(t[30:23])));
    endfunction

    function automatic logic [15:0] scaled_u16(input logic [31:0] v, input logic [31:0] s,
                                               input logic [31:0] o);
        logic [31:0] diff;
        diff = fp_add(v, o ^ SIGN_BIT);
        if (fp_is_zero(s)) begin
            // signed-zero divisor: NaN or zero numerator gives NaN, else signed inf
            if (fp_is_nan(diff) || fp_is_zero(diff))
                return 16'd0;
            return (diff[31] ^ s[31]) ? 16'd0 : fts_pkg::FULL_SCALE;
        end
        return trunc_clamp_u16(fp_add(fp_div(diff, s), fts_pkg::FP_HALF));
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH item %0d: %s", $realtime, n_out, what);
        fails++;
    endtask

    initial begin
        fails = 0;
        n_out = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                expected_q.push_back(scaled_u16(i_in_data[31:0], i_in_data[63:32],
                                                i_in_data[95:64]));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", i_out_data));
                else if (expected_q[0] !== i_out_data)
                    report_mismatch($sformatf("fixed_result %h, expected %h",
                                              i_out_data, expected_q[0]));
                if (expected_q.size() != 0)
                    void'(expected_q.pop_front());
                n_out++;
            end
        end
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for float_to_u16_scaled_convert_top
// Directed corner items, then random well-formed and raw binary32 triples,
// with bursty input and a changing output stall pattern.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_RANDOM   = 1430;
    localparam int DRAIN_WAIT = 60;     // pipeline is 38 deep

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [95:0] s_data;        // [31:0] value, [63:32] scale, [95:64] offset
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_data;        // [15:0] fixed_result
    int          fail_count;
    int          pending;

    int          gap_left;      // idle cycles before the next item
    int          burst_left;    // items left in the current burst
    int          stall_mode;
    int          stall_len;

    float_to_u16_scaled_convert_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    conv_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: modes of always ready, coin flip, and long stalls
    always @(posedge i_clk) begin
        if (stall_len == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_len  <= $urandom_range(1, 80);
        end else begin
            stall_len <= stall_len - 1;
        end
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= $urandom_range(0, 1);
            end
            default: begin
                m_ready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    // one item: optional gap, then hold valid until accepted
    task automatic send_item(input logic [31:0] v, input logic [31:0] sc,
                             input logic [31:0] off);
        bit took;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap_left > 0) begin
            s_valid <= 1'b0;
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end
        s_valid <= 1'b1;
        s_data  <= {off, sc, v};
        do begin
            @(negedge i_clk);
            took = s_ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    // float with random sign bias, exponent window and mantissa
    function automatic logic [31:0] rand_float(input int lo_exp, input int hi_exp,
                                               input int neg_pct);
        return {($urandom_range(0, 99) < neg_pct), 8'($urandom_range(lo_exp, hi_exp)),
                23'($urandom)};
    endfunction

    // raw pattern, sometimes forced to a zero or all-ones exponent or a zero mantissa
    function automatic logic [31:0] rand_raw();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: r[30:23] = 8'h00;
            1: r[30:23] = 8'hFF;
            2: r[22:0]  = ($urandom_range(0, 1)) ? 23'd0 : r[22:0];
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        logic [31:0] v, sc, off;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        stall_mode = 0;
        stall_len  = 0;
        burst_left = 0;
        gap_left   = 0;
        i_rst_n    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: value, scale, offset
        send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000); // 0 / 0
        send_item(32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000); // 1.5 -> 1
        send_item(32'h477F_FF00, 32'h3F80_0000, 32'h0000_0000); // 65535.5
        send_item(32'h4780_0000, 32'h3F80_0000, 32'h0000_0000); // 65536 clamps
        send_item(32'h7FC0_0000, 32'h3F80_0000, 32'h0000_0000); // NaN value
        send_item(32'h7F80_0000, 32'h3F80_0000, 32'h0000_0000); // +inf
        send_item(32'hFF80_0000, 32'h3F80_0000, 32'h0000_0000); // -inf
        send_item(32'h7F80_0000, 32'h3F80_0000, 32'h7F80_0000); // inf - inf
        send_item(32'h3F80_0000, 32'h0000_0000, 32'h0000_0000); // x / +0
        send_item(32'h3F80_0000, 32'h8000_0000, 32'h0000_0000); // x / -0
        send_item(32'h7F80_0000, 32'h7F80_0000, 32'h0000_0000); // inf / inf
        send_item(32'h3F80_0000, 32'h7F80_0000, 32'h0000_0000); // x / inf
        send_item(32'hBF80_0000, 32'h3F80_0000, 32'h0000_0000); // negative
        send_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0000); // subnormals
        send_item(32'h7F7F_FFFF, 32'h0000_0001, 32'h0000_0000); // overflow
        send_item(32'h3EFF_FFFF, 32'h3F80_0000, 32'h0000_0000); // just below 1
        send_item(32'h8000_0000, 32'h8000_0000, 32'h0000_0000); // -0 / -0
        send_item(32'h0000_0000, 32'h0000_0000, 32'h7FC0_0000); // NaN offset, zero scale
        send_item(32'h4120_0000, 32'hFFC0_0000, 32'h0000_0000); // NaN scale
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // all ones
        send_item(32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0000); // max / max
        send_item(32'hBF80_0000, 32'h807F_FFFF, 32'h0000_0000); // neg subnormal scale
        send_item(32'h4780_0000, 32'h4000_0000, 32'h4700_0000); // offset then halve
        send_item(32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000); // zero diff, zero scale

        for (int i = 0; i < N_RANDOM; i++) begin
            // hold off once until the pipeline has fully drained
            if (i == N_RANDOM / 2) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 99) < 65) begin
                // in-range conversions: results spread over 0..65535 and beyond
                sc  = rand_float(118, 136, 10);
                v   = rand_float(100, 150, 15);
                off = ($urandom_range(0, 3) == 0) ? 32'h0 : rand_float(90, 146, 40);
            end else begin
                v   = rand_raw();
                sc  = ($urandom_range(0, 9) == 0) ? {$urandom_range(0, 1) == 1, 31'd0}
                                                  : rand_raw();
                off = rand_raw();
            end
            send_item(v, sc, off);
        end
        s_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // generous ceiling well above the slowest correct run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fts_pkg.sv
rtl/fts_fp_add.sv
rtl/fts_fp_div.sv
rtl/float_to_u16_scaled_convert_top.sv
test/conv_checker.sv
test/tb_top.sv
